@@ src/imu_ca_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package imu_ca_pkg;

  localparam int unsigned IterW     = 5;   // covers the 22-entry arctan table
  localparam int unsigned SqrtSteps = 16;
  localparam int unsigned DivBits   = 48;
  localparam int unsigned DivCntW   = 2;
  localparam int unsigned DivDigits = 3;
  localparam int unsigned NumAxes   = 3;

  localparam logic [15:0]        BlendReset  = 16'd62915;
  localparam logic signed [31:0] AngHalfTurn = 32'sd5898240;
  localparam logic signed [31:0] AngFullTurn = 32'sd11796480;

  // ceil(2^30 / 125), exact floor division for dividends below 2^23
  localparam logic [23:0]        Recip125    = 24'd8589935;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_PREP, ST_ROLL, ST_SQRT, ST_PITCH_INIT, ST_PITCH, ST_DIV_WAIT,
    ST_GSUM_R, ST_MUL_R, ST_ADD_R, ST_GSUM_P, ST_MUL_P, ST_ADD_P, ST_YAW, ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    CFG_OFS_X, CFG_OFS_Y, CFG_OFS_Z, CFG_BLEND
  } cfg_idx_e;

  typedef enum logic {
    AXIS_ROLL, AXIS_PITCH
  } axis_e;

  typedef struct packed {
    logic             capture;
    logic             load;
    logic             prep;
    logic             cordic_step;
    logic             pitch_init;
    logic             sqrt_step;
    logic             gsum;
    logic             mul;
    logic             add;
    axis_e            axis;
    logic             yaw;
    logic             out_load;
    logic [IterW-1:0] iter;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } status_t;

  // atan(2^-i) in 1/32768 degree
  function automatic logic [21:0] atan_entry(input logic [IterW-1:0] i);
    logic [21:0] v;
    unique case (i)
      5'd0:    v = 22'd1474560;
      5'd1:    v = 22'd870484;
      5'd2:    v = 22'd459940;
      5'd3:    v = 22'd233473;
      5'd4:    v = 22'd117189;
      5'd5:    v = 22'd58652;
      5'd6:    v = 22'd29333;
      5'd7:    v = 22'd14667;
      5'd8:    v = 22'd7334;
      5'd9:    v = 22'd3667;
      5'd10:   v = 22'd1833;
      5'd11:   v = 22'd917;
      5'd12:   v = 22'd458;
      5'd13:   v = 22'd229;
      5'd14:   v = 22'd115;
      5'd15:   v = 22'd57;
      5'd16:   v = 22'd29;
      5'd17:   v = 22'd14;
      5'd18:   v = 22'd7;
      5'd19:   v = 22'd4;
      5'd20:   v = 22'd2;
      5'd21:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -50'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/imu_ca_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module imu_ca_ctrl
  import imu_ca_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire     clk_i,
  input  wire     rst_ni,
  input  wire     in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [IterW-1:0] StepsLast = IterW'(CORDIC_STEPS - 1);
  localparam logic [IterW-1:0] SqrtLast  = IterW'(SqrtSteps - 1);

  state_e           state_q, state_d;
  logic [IterW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = '0;
    unique case (state_q)
      ST_IDLE:       if (in_valid_i) state_d = ST_LOAD;
      ST_LOAD:       state_d = ST_PREP;
      ST_PREP:       state_d = ST_ROLL;
      ST_ROLL: begin
        if (cnt_q == StepsLast) state_d = ST_SQRT;
        else cnt_d = cnt_q + 1'b1;
      end
      ST_SQRT: begin
        if (cnt_q == SqrtLast) state_d = ST_PITCH_INIT;
        else cnt_d = cnt_q + 1'b1;
      end
      ST_PITCH_INIT: state_d = ST_PITCH;
      ST_PITCH: begin
        if (cnt_q == StepsLast) state_d = ST_DIV_WAIT;
        else cnt_d = cnt_q + 1'b1;
      end
      ST_DIV_WAIT:   if (!status_i.div_busy) state_d = ST_GSUM_R;
      ST_GSUM_R:     state_d = ST_MUL_R;
      ST_MUL_R:      state_d = ST_ADD_R;
      ST_ADD_R:      state_d = ST_GSUM_P;
      ST_GSUM_P:     state_d = ST_MUL_P;
      ST_MUL_P:      state_d = ST_ADD_P;
      ST_ADD_P:      state_d = ST_YAW;
      ST_YAW:        state_d = ST_OUT;
      ST_OUT:        if (status_i.out_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o        = (state_q == ST_IDLE);
    cmd_o             = '0;
    cmd_o.iter        = cnt_q;
    cmd_o.capture     = in_valid_i && (state_q == ST_IDLE);
    cmd_o.load        = (state_q == ST_LOAD);
    cmd_o.prep        = (state_q == ST_PREP);
    cmd_o.cordic_step = (state_q == ST_ROLL) || (state_q == ST_PITCH);
    cmd_o.sqrt_step   = (state_q == ST_SQRT);
    cmd_o.pitch_init  = (state_q == ST_PITCH_INIT);
    cmd_o.gsum        = (state_q == ST_GSUM_R) || (state_q == ST_GSUM_P);
    cmd_o.mul         = (state_q == ST_MUL_R) || (state_q == ST_MUL_P);
    cmd_o.add         = (state_q == ST_ADD_R) || (state_q == ST_ADD_P);
    cmd_o.axis        = ((state_q == ST_GSUM_P) || (state_q == ST_MUL_P) ||
                         (state_q == ST_ADD_P)) ? AXIS_PITCH : AXIS_ROLL;
    cmd_o.yaw         = (state_q == ST_YAW);
    cmd_o.out_load    = (state_q == ST_OUT) && status_i.out_free;
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_LOAD))
    else $error("accepted transaction did not start processing");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> status_i.out_free)
    else $error("result loaded over an untaken result");

  a_roll_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROLL && cnt_q == StepsLast) |=> (state_q == ST_SQRT))
    else $error("roll CORDIC ran wrong number of steps");

  a_gsum_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.gsum |-> !status_i.div_busy)
    else $error("gyro step used before divider finished");

endmodule

`default_nettype wire

@@ src/imu_ca_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module imu_ca_dp
  import imu_ca_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  input  wire               cfg_we_i,
  input  wire  [1:0]        cfg_index_i,
  input  wire  [18:0]       cfg_data_i,
  input  wire  signed [15:0] accel_x_i,
  input  wire  signed [15:0] accel_y_i,
  input  wire  signed [15:0] accel_z_i,
  input  wire  signed [18:0] rate_x_i,
  input  wire  signed [18:0] rate_y_i,
  input  wire  signed [18:0] rate_z_i,
  input  wire  [15:0]       elapsed_ms_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic signed [15:0] roll_angle_o,
  output logic signed [15:0] pitch_angle_o,
  output logic signed [15:0] yaw_angle_o
);

  function automatic logic signed [15:0] to_out(input logic signed [31:0] v);
    logic [31:0] mag;
    logic [32:0] sum;
    logic [24:0] q;
    logic signed [15:0] r;
    mag = v[31] ? 32'(-v) : 32'(v);
    sum = {1'b0, mag} + 33'd128;
    q   = sum[32:8];
    if (!v[31]) r = (q > 25'd32767) ? 16'sh7FFF : 16'(q);
    else r = (q > 25'd32768) ? 16'sh8000 : 16'(-q);
    return r;
  endfunction

  // configuration
  logic signed [18:0] ofs_q [NumAxes];
  logic [15:0]        alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumAxes; k++) ofs_q[k] <= '0;
      alpha_q <= BlendReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_OFS_X: ofs_q[0] <= cfg_data_i;
        CFG_OFS_Y: ofs_q[1] <= cfg_data_i;
        CFG_OFS_Z: ofs_q[2] <= cfg_data_i;
        CFG_BLEND: alpha_q  <= cfg_data_i[15:0];
        default:   ;
      endcase
    end
  end

  // input capture and first products
  logic signed [15:0] ax_q, ay_q, az_q;
  logic signed [18:0] rate_q [NumAxes];
  logic [15:0]        ms_q;
  logic signed [36:0] prod_q [NumAxes];
  logic signed [31:0] sqy_q, sqz_q;
  logic signed [19:0] diff [NumAxes];

  always_comb begin
    for (int k = 0; k < NumAxes; k++) begin
      diff[k] = 20'(rate_q[k]) - 20'(ofs_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ax_q      <= accel_x_i;
      ay_q      <= accel_y_i;
      az_q      <= accel_z_i;
      rate_q[0] <= rate_x_i;
      rate_q[1] <= rate_y_i;
      rate_q[2] <= rate_z_i;
      ms_q      <= elapsed_ms_i;
    end
    if (cmd_i.load) begin
      for (int k = 0; k < NumAxes; k++) begin
        prod_q[k] <= diff[k] * $signed({1'b0, ms_q});
      end
      sqy_q <= ay_q * ay_q;
      sqz_q <= az_q * az_q;
    end
  end

  // gyro step dividers: round(|p| * 256 / 1000) = floor((32 * |p| + 62) / 125),
  // long division by 125 in 16-bit digits, one digit per cycle by reciprocal multiply
  logic [DivCntW-1:0] div_cnt_q;
  logic [DivBits-1:0] dq_q  [NumAxes];
  logic [6:0]         rem_q [NumAxes];
  logic               neg_q [NumAxes];
  logic [36:0]        pmag  [NumAxes];
  logic [22:0]        dvd   [NumAxes];
  logic [46:0]        dprod [NumAxes];
  logic [15:0]        qdig  [NumAxes];
  logic [6:0]         rem_n [NumAxes];
  logic signed [34:0] step  [NumAxes];

  always_comb begin
    for (int k = 0; k < NumAxes; k++) begin
      pmag[k]  = prod_q[k][36] ? 37'(-prod_q[k]) : 37'(prod_q[k]);
      dvd[k]   = {rem_q[k], dq_q[k][DivBits-1 -: 16]};
      dprod[k] = dvd[k] * Recip125;
      qdig[k]  = dprod[k][45:30];
      // remainder is below 128: dvd - 125*q taken mod 128 is dvd + 3*q
      rem_n[k] = dvd[k][6:0] + {qdig[k][5:0], 1'b0} + qdig[k][6:0];
      step[k]  = neg_q[k] ? -$signed({1'b0, dq_q[k][33:0]}) : $signed({1'b0, dq_q[k][33:0]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.prep) begin
      div_cnt_q <= DivCntW'(DivDigits);
    end else if (div_cnt_q != '0) begin
      div_cnt_q <= div_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumAxes; k++) begin
      if (cmd_i.prep) begin
        dq_q[k]  <= {8'd0, pmag[k][34:0], 5'd0} + 48'd62;
        rem_q[k] <= '0;
        neg_q[k] <= prod_q[k][36];
      end else if (div_cnt_q != '0) begin
        rem_q[k] <= rem_n[k];
        dq_q[k]  <= {dq_q[k][DivBits-17:0], qdig[k]};
      end
    end
  end

  // integer square root of ay^2 + az^2, two radicand bits per cycle
  logic [32:0] sv_q, sr_q, sbit_q;
  logic [32:0] s_try;
  assign s_try = sr_q + sbit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      sv_q   <= 33'($unsigned(sqy_q)) + 33'($unsigned(sqz_q));
      sr_q   <= '0;
      sbit_q <= 33'd1 << 30;
    end else if (cmd_i.sqrt_step) begin
      if (sv_q >= s_try) begin
        sv_q <= sv_q - s_try;
        sr_q <= (sr_q >> 1) + sbit_q;
      end else begin
        sr_q <= sr_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
    end
  end

  // shared vectoring CORDIC
  logic signed [33:0] cx_q, cy_q;
  logic signed [25:0] cz_q;
  logic               zero_q;
  logic signed [25:0] tilt_roll_q;
  logic signed [33:0] in_x, in_y, xs, ys;
  logic signed [25:0] atan_v, cz_res;

  always_comb begin
    if (cmd_i.pitch_init) begin
      in_y = 34'(-(17'(ax_q))) <<< 14;
      in_x = $signed({18'd0, sr_q[15:0]}) <<< 14;
    end else begin
      in_y = 34'(ay_q) <<< 14;
      in_x = 34'(az_q) <<< 14;
    end
    xs     = cx_q >>> cmd_i.iter;
    ys     = cy_q >>> cmd_i.iter;
    atan_v = $signed({4'd0, atan_entry(cmd_i.iter)});
    cz_res = zero_q ? 26'sd0 : cz_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep || cmd_i.pitch_init) begin
      zero_q <= (in_x == '0) && (in_y == '0);
      if (in_x < 0) begin
        cz_q <= (in_y >= 0) ? 26'(AngHalfTurn) : -26'(AngHalfTurn);
        cx_q <= -in_x;
        cy_q <= -in_y;
      end else begin
        cz_q <= '0;
        cx_q <= in_x;
        cy_q <= in_y;
      end
    end else if (cmd_i.cordic_step) begin
      if (cy_q >= 0) begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        cz_q <= cz_q + atan_v;
      end else begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        cz_q <= cz_q - atan_v;
      end
    end
    if (cmd_i.pitch_init) tilt_roll_q <= cz_res;
  end

  // blend and yaw
  logic signed [31:0] roll_q, pitch_q, yaw_q;
  logic signed [31:0] g_q;
  logic signed [48:0] pg_q;
  logic signed [43:0] pa_q;
  logic signed [31:0] st_sel;
  logic signed [34:0] step_sel;
  logic signed [25:0] acc_sel;
  logic signed [49:0] num;
  logic signed [31:0] yaw_sat;
  logic signed [32:0] yaw_wrap;

  always_comb begin
    st_sel   = (cmd_i.axis == AXIS_PITCH) ? pitch_q : roll_q;
    step_sel = (cmd_i.axis == AXIS_PITCH) ? step[1] : step[0];
    acc_sel  = (cmd_i.axis == AXIS_PITCH) ? cz_res : tilt_roll_q;
    num      = 50'(pg_q) + 50'(pa_q) + 50'sd32768;
    yaw_sat  = sat32(50'(yaw_q) + 50'(step[2]));
    if (yaw_sat > AngHalfTurn) yaw_wrap = 33'(yaw_sat) - 33'(AngFullTurn);
    else if (yaw_sat < -AngHalfTurn) yaw_wrap = 33'(yaw_sat) + 33'(AngFullTurn);
    else yaw_wrap = 33'(yaw_sat);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.gsum) g_q <= sat32(50'(st_sel) + 50'(step_sel));
    if (cmd_i.mul) begin
      pg_q <= $signed({1'b0, alpha_q}) * g_q;
      pa_q <= $signed({1'b0, 17'd65536 - 17'(alpha_q)}) * acc_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_q  <= '0;
      pitch_q <= '0;
      yaw_q   <= '0;
    end else begin
      if (cmd_i.add && cmd_i.axis == AXIS_ROLL) roll_q <= sat32(num >>> 16);
      if (cmd_i.add && cmd_i.axis == AXIS_PITCH) pitch_q <= sat32(num >>> 16);
      if (cmd_i.yaw) yaw_q <= yaw_wrap[31:0];
    end
  end

  // result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      roll_angle_o  <= to_out(roll_q);
      pitch_angle_o <= to_out(pitch_q);
      yaw_angle_o   <= to_out(yaw_q);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.div_busy = (div_cnt_q != '0);

endmodule

`default_nettype wire

@@ src/imu_complementary_attitude_top.sv @@
// From input transaction to result valid: roll CORDIC, isqrt, pitch CORDIC, blend, yaw, output;
//   the three-digit gyro-step divider finishes during the roll CORDIC.
// Samples are taken one at a time; the shared CORDIC and isqrt run in turn.
// A finished result waits in the output register while the next sample is accepted.
// Reset (async, active low): angles cleared, offsets 0, blend weight 62915.
`timescale 1ns / 1ps
`default_nettype none

module imu_complementary_attitude_top
  import imu_ca_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire  [1:0]        cfg_index_i,
  input  wire  [18:0]       cfg_data_i,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire  signed [15:0] accel_x_i,
  input  wire  signed [15:0] accel_y_i,
  input  wire  signed [15:0] accel_z_i,
  input  wire  signed [18:0] rate_x_i,
  input  wire  signed [18:0] rate_y_i,
  input  wire  signed [18:0] rate_z_i,
  input  wire  [15:0]       elapsed_ms_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic signed [15:0] roll_angle_o,
  output logic signed [15:0] pitch_angle_o,
  output logic signed [15:0] yaw_angle_o
);

  cmd_t    cmd;
  status_t status;

  imu_ca_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  imu_ca_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .accel_x_i     (accel_x_i),
    .accel_y_i     (accel_y_i),
    .accel_z_i     (accel_z_i),
    .rate_x_i      (rate_x_i),
    .rate_y_i      (rate_y_i),
    .rate_z_i      (rate_z_i),
    .elapsed_ms_i  (elapsed_ms_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .roll_angle_o  (roll_angle_o),
    .pitch_angle_o (pitch_angle_o),
    .yaw_angle_o   (yaw_angle_o)
  );

endmodule

`default_nettype wire
